// File: hw/rtl/aoot_pkg.sv
// shared types and constants for the box overlap test core
package aoot_pkg;

   localparam int AXES = 3;
   localparam int LANE_W = 16;
   localparam int PACK_W = 48;
   localparam int CUT_W = 15;
   localparam int FRAC_AXIS = 14;
   localparam int SUM_W = 36;
   localparam int TESTS = 15;
   localparam int IDX_W = 3;

   typedef enum logic [IDX_W-1:0] {
      REG_BOX_CENTRE = 3'd0,
      REG_BOX_HALF = 3'd1,
      REG_AXIS_U = 3'd2,
      REG_AXIS_V = 3'd3,
      REG_AXIS_W = 3'd4,
      REG_CUTOFF = 3'd5
   } reg_idx_type;

   typedef logic signed [15:0] comp_type;
   typedef logic [15:0] mag_type;
   typedef logic signed [16:0] dist_type;
   typedef logic [14:0] ext_type;
   typedef logic signed [32:0] dprod_type;
   typedef logic [31:0] uprod_type;
   typedef logic signed [SUM_W-1:0] wide_type;

   typedef struct packed {
      logic [PACK_W-1:0] centre;
      logic [PACK_W-1:0] half;
      logic [AXES-1:0][PACK_W-1:0] axis;
      logic [CUT_W-1:0] cutoff;
   } cfg_type;

   typedef struct packed {
      comp_type [AXES-1:0][AXES-1:0] ax;
      mag_type [AXES-1:0][AXES-1:0] ab;
      mag_type [AXES-1:0] e1;
      logic parallel;
   } geo_type;

endpackage

// File: hw/rtl/aoot_prep.sv
// stage 1: centre offsets, query extents and box axis magnitudes
module aoot_prep (
   input  logic clock,
   input  logic reset,
   input  aoot_pkg::cfg_type cfg,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [15:0] cx,
   input  logic signed [15:0] cy,
   input  logic signed [15:0] cz,
   input  logic [14:0] hx,
   input  logic [14:0] hy,
   input  logic [14:0] hz,
   output aoot_pkg::geo_type geo,
   output logic out_valid,
   input  logic out_ready,
   output aoot_pkg::dist_type [2:0] d,
   output aoot_pkg::ext_type [2:0] e0
);
   import aoot_pkg::*;

   logic valid_ff;
   dist_type [AXES-1:0] d_ff, d_in;
   ext_type [AXES-1:0] e0_ff, e0_in;
   comp_type [AXES-1:0] qc;

   assign qc = {cz, cy, cx};
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      logic signed [16:0] t;
      geo.parallel = 1'b0;
      for (int j = 0; j < AXES; j++) begin
         geo.e1[j] = cfg.half[j*LANE_W +: LANE_W];
         for (int i = 0; i < AXES; i++) begin
            geo.ax[j][i] = cfg.axis[j][i*LANE_W +: LANE_W];
            t = {geo.ax[j][i][15], geo.ax[j][i]};
            geo.ab[j][i] = (t < 0) ? 16'(-t) : 16'(t);
            if (geo.ab[j][i] >= {1'b0, cfg.cutoff}) begin
               geo.parallel = 1'b1;
            end
         end
      end
      for (int i = 0; i < AXES; i++) begin
         d_in[i] = {cfg.centre[i*LANE_W + 15], cfg.centre[i*LANE_W +: LANE_W]}
                   - {qc[i][15], qc[i]};
      end
      e0_in = {hz, hy, hx};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         d_ff <= d_in;
         e0_ff <= e0_in;
      end
   end

   assign out_valid = valid_ff;
   assign d = d_ff;
   assign e0 = e0_ff;

endmodule

// File: hw/rtl/aoot_mult.sv
// stage 2: all projection products, one multiplier each
module aoot_mult (
   input  logic clock,
   input  logic reset,
   input  aoot_pkg::geo_type geo,
   input  logic in_valid,
   output logic in_ready,
   input  aoot_pkg::dist_type [2:0] d,
   input  aoot_pkg::ext_type [2:0] e0,
   output logic out_valid,
   input  logic out_ready,
   output aoot_pkg::dprod_type [2:0][2:0][2:0] pd,
   output aoot_pkg::uprod_type [2:0][2:0][2:0] pe0,
   output aoot_pkg::uprod_type [2:0][2:0][2:0] pe1,
   output aoot_pkg::mag_type [2:0] dabs,
   output aoot_pkg::ext_type [2:0] e0_out
);
   import aoot_pkg::*;

   logic valid_ff;
   dprod_type [AXES-1:0][AXES-1:0][AXES-1:0] pd_ff, pd_in;
   uprod_type [AXES-1:0][AXES-1:0][AXES-1:0] pe0_ff, pe0_in, pe1_ff, pe1_in;
   mag_type [AXES-1:0] dabs_ff, dabs_in;
   ext_type [AXES-1:0] e0_ff;

   assign in_ready = !valid_ff || out_ready;

   // pd[j][k][m] = d[k] * u_j[m], pe0[j][m][n] = e0[m] * |u_j[n]|,
   // pe1[a][b][i] = e1[a] * |u_b[i]|
   always_comb begin
      for (int j = 0; j < AXES; j++) begin
         for (int k = 0; k < AXES; k++) begin
            for (int m = 0; m < AXES; m++) begin
               pd_in[j][k][m] = d[k] * geo.ax[j][m];
               pe0_in[j][k][m] = {1'b0, 31'(e0[k] * geo.ab[j][m])};
               pe1_in[j][k][m] = geo.e1[j] * geo.ab[k][m];
            end
         end
      end
      for (int i = 0; i < AXES; i++) begin
         dabs_in[i] = (d[i] < 0) ? 16'(-d[i]) : 16'(d[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         pd_ff <= pd_in;
         pe0_ff <= pe0_in;
         pe1_ff <= pe1_in;
         dabs_ff <= dabs_in;
         e0_ff <= e0;
      end
   end

   assign out_valid = valid_ff;
   assign pd = pd_ff;
   assign pe0 = pe0_ff;
   assign pe1 = pe1_ff;
   assign dabs = dabs_ff;
   assign e0_out = e0_ff;

endmodule

// File: hw/rtl/aoot_reduce.sv
// stages 3 and 4: radius sums per axis, then compare and combine
module aoot_reduce (
   input  logic clock,
   input  logic reset,
   input  logic parallel,
   input  aoot_pkg::mag_type [2:0] e1,
   input  logic in_valid,
   output logic in_ready,
   input  aoot_pkg::dprod_type [2:0][2:0][2:0] pd,
   input  aoot_pkg::uprod_type [2:0][2:0][2:0] pe0,
   input  aoot_pkg::uprod_type [2:0][2:0][2:0] pe1,
   input  aoot_pkg::mag_type [2:0] dabs,
   input  aoot_pkg::ext_type [2:0] e0,
   output logic out_valid,
   input  logic out_ready,
   output logic overlap
);
   import aoot_pkg::*;

   logic valid3_ff, valid4_ff, ready4;
   wide_type [TESTS-1:0] r_ff, r_in, rhs_ff, rhs_in;
   logic [TESTS-1:0] sep;
   logic ovl_ff, ovl_in;

   function automatic wide_type absw(input wide_type v);
      return (v < 0) ? -v : v;
   endfunction

   // world axes
   for (genvar gi = 0; gi < AXES; gi++) begin : g_world
      assign r_in[gi] = wide_type'({dabs[gi], FRAC_AXIS'(0)});
      assign rhs_in[gi] = wide_type'({e0[gi], FRAC_AXIS'(0)}) + wide_type'(pe1[0][0][gi])
                          + wide_type'(pe1[1][1][gi]) + wide_type'(pe1[2][2][gi]);
   end

   // box axes
   for (genvar gj = 0; gj < AXES; gj++) begin : g_box
      assign r_in[AXES + gj] = absw(wide_type'(pd[gj][0][0]) + wide_type'(pd[gj][1][1])
                                    + wide_type'(pd[gj][2][2]));
      assign rhs_in[AXES + gj] = wide_type'(pe0[gj][0][0]) + wide_type'(pe0[gj][1][1])
                                 + wide_type'(pe0[gj][2][2])
                                 + wide_type'({e1[gj], FRAC_AXIS'(0)});
   end

   // cross axes: world axis i x box axis j
   for (genvar gi = 0; gi < AXES; gi++) begin : g_ci
      localparam int I1 = (gi + 1) % 3;
      localparam int I2 = (gi + 2) % 3;
      for (genvar gj = 0; gj < AXES; gj++) begin : g_cj
         localparam int J1 = (gj + 1) % 3;
         localparam int J2 = (gj + 2) % 3;
         localparam int T = 2 * AXES + gi * AXES + gj;
         assign r_in[T] = absw(wide_type'(pd[gj][I2][I1]) - wide_type'(pd[gj][I1][I2]));
         assign rhs_in[T] = wide_type'(pe0[gj][I1][I2]) + wide_type'(pe0[gj][I2][I1])
                            + wide_type'(pe1[J1][J2][gi]) + wide_type'(pe1[J2][J1][gi]);
      end
   end

   always_comb begin
      for (int t = 0; t < TESTS; t++) begin
         sep[t] = r_ff[t] > rhs_ff[t];
      end
      ovl_in = !(|sep[2*AXES-1:0]) && (parallel || !(|sep[TESTS-1:2*AXES]));
   end

   assign ready4 = !valid4_ff || out_ready;
   assign in_ready = !valid3_ff || ready4;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            valid3_ff <= in_valid;
         end
         if (ready4) begin
            valid4_ff <= valid3_ff;
         end
      end
      if (in_ready) begin
         r_ff <= r_in;
         rhs_ff <= rhs_in;
      end
      if (ready4) begin
         ovl_ff <= ovl_in;
      end
   end

   assign out_valid = valid4_ff;
   assign overlap = ovl_ff;

endmodule

// File: hw/rtl/aabb_obb_overlap_test_core.sv
// top level of the oriented box versus axis-aligned box overlap test
// Streams axis-aligned query boxes (centre and half extents, Q11.4) against one oriented box
// held in configuration registers and answers, per query, whether a separating axis exists
// among the three world axes, the three box axes and, unless some box axis is nearly parallel
// to a world axis, the nine cross axes. One query is taken every cycle while req_stall is
// low; each answer passes through four registered stages (offset stage, product stage, sum
// stage, compare stage), with every stage holding its own valid bit so bubbles close up
// under stall. Configuration writes are always taken and must only happen while no query
// is in flight.
module aabb_obb_overlap_test_core (
   input  logic clock,
   input  logic reset,
   // query channel
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [15:0] req_query_centre_x,
   input  logic signed [15:0] req_query_centre_y,
   input  logic signed [15:0] req_query_centre_z,
   input  logic [14:0] req_query_half_x,
   input  logic [14:0] req_query_half_y,
   input  logic [14:0] req_query_half_z,
   // result channel
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_boxes_overlap,
   // register write channel
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [aoot_pkg::IDX_W-1:0] csr_index,
   input  logic [aoot_pkg::PACK_W-1:0] csr_wdata
);
   import aoot_pkg::*;

   cfg_type cfg_ff;
   geo_type geo;
   logic p_valid, p_ready, m_valid, m_ready, in_ready;
   dist_type [AXES-1:0] d;
   ext_type [AXES-1:0] e0, m_e0;
   dprod_type [AXES-1:0][AXES-1:0][AXES-1:0] pd;
   uprod_type [AXES-1:0][AXES-1:0][AXES-1:0] pe0, pe1;
   mag_type [AXES-1:0] dabs;

   // register file, writes never stall
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.centre <= '0;
         cfg_ff.half <= '0;
         cfg_ff.axis[0] <= PACK_W'(1) << FRAC_AXIS;
         cfg_ff.axis[1] <= PACK_W'(1) << (LANE_W + FRAC_AXIS);
         cfg_ff.axis[2] <= PACK_W'(1) << (2 * LANE_W + FRAC_AXIS);
         cfg_ff.cutoff <= CUT_W'((1 << FRAC_AXIS) - 1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BOX_CENTRE: cfg_ff.centre <= csr_wdata;
            REG_BOX_HALF:   cfg_ff.half <= csr_wdata;
            REG_AXIS_U:     cfg_ff.axis[0] <= csr_wdata;
            REG_AXIS_V:     cfg_ff.axis[1] <= csr_wdata;
            REG_AXIS_W:     cfg_ff.axis[2] <= csr_wdata;
            REG_CUTOFF:     cfg_ff.cutoff <= csr_wdata[CUT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = !in_ready;

   // offset of centres, axis magnitudes, parallel flag
   aoot_prep u_prep (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(req_valid), .in_ready(in_ready),
      .cx(req_query_centre_x), .cy(req_query_centre_y), .cz(req_query_centre_z),
      .hx(req_query_half_x), .hy(req_query_half_y), .hz(req_query_half_z),
      .geo(geo), .out_valid(p_valid), .out_ready(p_ready), .d(d), .e0(e0)
   );

   // every product needed by the fifteen axis tests
   aoot_mult u_mult (
      .clock(clock), .reset(reset), .geo(geo),
      .in_valid(p_valid), .in_ready(p_ready), .d(d), .e0(e0),
      .out_valid(m_valid), .out_ready(m_ready),
      .pd(pd), .pe0(pe0), .pe1(pe1), .dabs(dabs), .e0_out(m_e0)
   );

   // sums, compares and final answer; the last register is the result register
   aoot_reduce u_reduce (
      .clock(clock), .reset(reset), .parallel(geo.parallel), .e1(geo.e1),
      .in_valid(m_valid), .in_ready(m_ready),
      .pd(pd), .pe0(pe0), .pe1(pe1), .dabs(dabs), .e0(m_e0),
      .out_valid(rsp_valid), .out_ready(!rsp_stall), .overlap(rsp_boxes_overlap)
   );

endmodule

// File: hw/rtl/aoot_checker.sv
// port-level checks for the overlap test core and their binding
module aoot_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_boxes_overlap,
   input logic csr_ready
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_boxes_overlap))
      else $error("result changed under stall");

   // with the result register empty the pipeline always has room
   a_room: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // no result right out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // register writes are never refused
   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register write refused");

endmodule

bind aabb_obb_overlap_test_core aoot_checker u_aoot_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_boxes_overlap(rsp_boxes_overlap), .csr_ready(csr_ready)
);
